// ===== hdl/led_frame_word_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// led_frame_word_deframer_macros.svh
// Assertion macros used by the deframer core.
// ----------------------------------------------------------------------------
`ifndef LED_FRAME_WORD_DEFRAMER_MACROS_SVH
`define LED_FRAME_WORD_DEFRAMER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LFWD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LFWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lfwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfwd_pkg
// Types and constants of the LED frame word deframer.
// ----------------------------------------------------------------------------
package lfwd_pkg;

    // Frame geometry
    localparam int SLOT_COUNT = 2048;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int IDX_W      = 11;
    // Holds any start slot and the full count itself
    localparam int SLOT_W     = IDX_W + 1;

    localparam logic [IDX_W-1:0]  START_SLOT_RESET = IDX_W'(3 * 3 * 15);
    localparam logic [WORD_W-1:0] END_MARK         = 16'hffff;
    localparam logic [WORD_W-1:0] CLOSE_WORD       = 16'hf0ff;
    localparam logic [WORD_W-1:0] TOP_VALUE        = 16'hff00;
    localparam logic [BYTE_W-1:0] RESYNC_BYTE      = 8'hf0;

    typedef enum logic [0:0] {
        EV_WRITE = 1'b0,
        EV_END   = 1'b1
    } t_event_kind;

    typedef struct packed {
        t_event_kind       kind;
        logic [IDX_W-1:0]  slot_index;
        logic [WORD_W-1:0] slot_value;
        logic              frame_good;
    } t_result;

endpackage

// ===== hdl/lfwd_in_stage.sv =====
// ----------------------------------------------------------------------------
// lfwd_in_stage
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module lfwd_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [lfwd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                       i_advance,
    output logic                       o_item_valid,
    output logic [lfwd_pkg::BYTE_W-1:0] o_item_byte
);
    import lfwd_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    // Stall only while a held item cannot move on
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // Hold valid and byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item_byte  = r_byte;

endmodule

// ===== hdl/lfwd_core.sv =====
// ----------------------------------------------------------------------------
// lfwd_core
// Frame state and per-byte decode: word pairing, end mark, close and resync.
// ----------------------------------------------------------------------------
`include "led_frame_word_deframer_macros.svh"

module lfwd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lfwd_pkg::IDX_W-1:0]  i_start_slot,
    input  logic                        i_item_valid,
    input  logic [lfwd_pkg::BYTE_W-1:0] i_item_byte,
    input  logic                        i_out_free,
    output logic                        o_fire,
    output logic                        o_result_valid,
    output lfwd_pkg::t_result           o_result
);
    import lfwd_pkg::*;

    logic              r_high_pending, n_high_pending;
    logic [BYTE_W-1:0] r_held_low,     n_held_low;
    logic [SLOT_W-1:0] r_write_slot,   n_write_slot;
    logic              r_end_seen,     n_end_seen;
    logic              r_good,         n_good;

    logic              has_result;
    t_result           result;
    logic [WORD_W-1:0] word;
    logic              good_after;
    logic              new_frame;

    assign word = {i_item_byte, r_held_low};

    // Decode the byte against the frame state
    always_comb begin
        has_result         = 1'b0;
        new_frame          = 1'b0;
        result.kind        = EV_WRITE;
        result.slot_index  = '0;
        result.slot_value  = '0;
        result.frame_good  = 1'b0;
        good_after         = r_good;
        n_high_pending     = r_high_pending;
        n_held_low         = r_held_low;
        n_write_slot       = r_write_slot;
        n_end_seen         = r_end_seen;
        n_good             = r_good;

        if (!r_high_pending) begin
            if (r_end_seen && i_item_byte == RESYNC_BYTE) begin
                has_result        = 1'b1;
                new_frame         = 1'b1;
                result.kind       = EV_END;
                result.frame_good = 1'b0;
            end else begin
                n_held_low     = i_item_byte;
                n_high_pending = 1'b1;
            end
        end else begin
            n_high_pending = 1'b0;
            if (word == END_MARK) begin
                n_good     = !r_end_seen;
                n_end_seen = 1'b1;
            end else if (r_end_seen && word == CLOSE_WORD) begin
                has_result        = 1'b1;
                new_frame         = 1'b1;
                result.kind       = EV_END;
                result.frame_good = r_good;
            end else begin
                // Spoil on a stray word after the end mark or an oversized value
                good_after = r_good && !r_end_seen && (word <= TOP_VALUE);
                n_good     = good_after;
                if (good_after && r_write_slot < SLOT_W'(SLOT_COUNT)) begin
                    has_result        = 1'b1;
                    result.kind       = EV_WRITE;
                    result.slot_index = r_write_slot[IDX_W-1:0];
                    result.slot_value = word;
                    n_write_slot      = r_write_slot + SLOT_W'(1);
                end
            end
        end

        // Restore frame state after each frame end
        if (new_frame) begin
            n_high_pending = 1'b0;
            n_held_low     = '0;
            n_write_slot   = {1'b0, i_start_slot};
            n_end_seen     = 1'b0;
            n_good         = 1'b1;
        end
    end

    // Advance when the result slot is free or no result is due
    assign o_fire         = i_item_valid && (i_out_free || !has_result);
    assign o_result_valid = o_fire && has_result;
    assign o_result       = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_held_low     <= '0;
            r_write_slot   <= {1'b0, START_SLOT_RESET};
            r_end_seen     <= 1'b0;
            r_good         <= 1'b1;
        end else if (o_fire) begin
            r_high_pending <= n_high_pending;
            r_held_low     <= n_held_low;
            r_write_slot   <= n_write_slot;
            r_end_seen     <= n_end_seen;
            r_good         <= n_good;
        end
    end

    `LFWD_ASSERT_NEXT(a_end_restores, i_clk, i_rst_n, o_result_valid && result.kind == EV_END, !r_end_seen && r_good && !r_high_pending, "frame state not restored after frame end")
    `LFWD_ASSERT_IMP(a_write_in_range, i_clk, i_rst_n, o_result_valid && result.kind == EV_WRITE, r_write_slot < SLOT_W'(SLOT_COUNT) && word <= TOP_VALUE && r_good && !r_end_seen, "value write outside frame rules")
    `LFWD_ASSERT_NEXT(a_slot_step, i_clk, i_rst_n, o_result_valid && result.kind == EV_WRITE, r_write_slot == $past(r_write_slot) + SLOT_W'(1), "write slot did not advance by one")
    `LFWD_ASSERT_IMP(a_no_result_low, i_clk, i_rst_n, o_result_valid && !r_high_pending, result.kind == EV_END && !result.frame_good, "low byte gave a result other than resync")

endmodule

// ===== hdl/lfwd_out_stage.sv =====
// ----------------------------------------------------------------------------
// lfwd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lfwd_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  lfwd_pkg::t_result           i_result,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_event_kind,
    output logic [lfwd_pkg::IDX_W-1:0]  o_slot_index,
    output logic [lfwd_pkg::WORD_W-1:0] o_slot_value,
    output logic                        o_frame_good
);
    import lfwd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or when the held item leaves this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_event_kind = r_result.kind;
    assign o_slot_index = r_result.slot_index;
    assign o_slot_value = r_result.slot_value;
    assign o_frame_good = r_result.frame_good;

endmodule

// ===== hdl/led_frame_word_deframer.sv =====
// ----------------------------------------------------------------------------
// led_frame_word_deframer
// Pairs received bytes into little-endian words and turns them into slot
// writes and frame end reports.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall   i_rx_byte
//   out      output     o_out_valid/i_out_stall event_kind, slot_index,
//                                               slot_value, frame_good
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_start_slot
//
// One byte per cycle while no result is blocked; a byte passes the input
// register, then decode into the result register.
// Reset (synchronous, active low) empties both registers, sets the start
// slot to 135 and opens a fresh frame.
// A stalled result blocks only a byte that would make a result; bytes that
// make none keep flowing. A start slot write applies from the next frame.
// ----------------------------------------------------------------------------
module led_frame_word_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lfwd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_event_kind,
    output logic [lfwd_pkg::IDX_W-1:0]  o_slot_index,
    output logic [lfwd_pkg::WORD_W-1:0] o_slot_value,
    output logic                        o_frame_good,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lfwd_pkg::IDX_W-1:0]  i_cfg_start_slot
);
    import lfwd_pkg::*;

    logic [IDX_W-1:0]  r_start_slot;
    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              fire;
    logic              out_free;
    logic              result_valid;
    t_result           result;

    // Take configuration at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_slot <= START_SLOT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_slot <= i_cfg_start_slot;
        end
    end

    lfwd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_advance    (fire),
        .o_item_valid (item_valid),
        .o_item_byte  (item_byte)
    );

    lfwd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_slot   (r_start_slot),
        .i_item_valid   (item_valid),
        .i_item_byte    (item_byte),
        .i_out_free     (out_free),
        .o_fire         (fire),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    lfwd_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (result_valid),
        .i_result     (result),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_slot_index (o_slot_index),
        .o_slot_value (o_slot_value),
        .o_frame_good (o_frame_good)
    );

endmodule

// ===== bench/tb_led_frame_word_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_led_frame_word_deframer
// Self-checking bench for the LED frame word deframer. A short directed
// table covers end marks, close words, resync and spoiled frames.
// Random frames follow under several start slots, some near the top slot so
// frames fill up, with random gaps on the byte side and random stalls on the
// result side. Every accepted byte runs through a local frame tracker;
// accepted results are compared in order.
// ----------------------------------------------------------------------------
module tb_led_frame_word_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import lfwd_pkg::*;

    localparam int          PHASE_ITEMS = 70;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam t_result     NO_RESULT   = '0;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                pinned;   // expectation typed in below
        bit                has_res;
        t_result           res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_rx_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_event_kind;
    logic [IDX_W-1:0]   o_slot_index;
    logic [WORD_W-1:0]  o_slot_value;
    logic               o_frame_good;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_start_slot;

    led_frame_word_deframer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_kind     (o_event_kind),
        .o_slot_index     (o_slot_index),
        .o_slot_value     (o_slot_value),
        .o_frame_good     (o_frame_good),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_start_slot (i_cfg_start_slot)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Frame tracker state
    logic [IDX_W-1:0]  trk_start_slot;
    logic              trk_high_pending;
    logic [BYTE_W-1:0] trk_low_byte;
    logic [SLOT_W-1:0] trk_write_slot;
    logic              trk_mark_seen;
    logic              trk_still_good;

    t_result           pending_results[$];
    int                fail_count = 0;
    int unsigned       cycle_count = 0;

    // Expectation that goes with the byte on the bus
    bit                row_pinned = 1'b0;
    bit                row_has_res = 1'b0;
    t_result           row_res = NO_RESULT;

    bit                burst = 1'b0;
    int                stall_left = 0;
    int                free_left = 0;
    int                stall_roll;
    logic [BYTE_W-1:0] frame_bytes[$];

    function automatic void open_frame();
        trk_high_pending = 1'b0;
        trk_low_byte     = '0;
        trk_write_slot   = {1'b0, trk_start_slot};
        trk_mark_seen    = 1'b0;
        trk_still_good   = 1'b1;
    endfunction

    function automatic bit close_frame(input bit good, output t_result res);
        res = '{EV_END, '0, '0, good};
        open_frame();
        return 1'b1;
    endfunction

    // Advance the tracker by one byte; return 1 when it makes a result
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] rx, output t_result res);
        logic [WORD_W-1:0] word;
        res = NO_RESULT;
        if (!trk_high_pending) begin
            if (trk_mark_seen && rx == RESYNC_BYTE) begin
                return close_frame(1'b0, res);
            end
            trk_low_byte     = rx;
            trk_high_pending = 1'b1;
            return 1'b0;
        end
        trk_high_pending = 1'b0;
        word = {rx, trk_low_byte};
        if (word == END_MARK) begin
            trk_still_good = !trk_mark_seen;
            trk_mark_seen  = 1'b1;
            return 1'b0;
        end
        if (trk_mark_seen) begin
            if (word == CLOSE_WORD) begin
                return close_frame(trk_still_good, res);
            end
            trk_still_good = 1'b0;
        end
        if (word > TOP_VALUE) begin
            trk_still_good = 1'b0;
        end
        if (trk_write_slot < SLOT_COUNT && trk_still_good) begin
            res = '{EV_WRITE, trk_write_slot[IDX_W-1:0], word, 1'b0};
            trk_write_slot = trk_write_slot + 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Monitor: check results first, then track the byte taken at this edge
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result made;
        bit      got;
        if (!i_rst_n) begin
            trk_start_slot = START_SLOT_RESET;
            open_frame();
            pending_results.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: kind=%0d idx=%0d val=%h good=%0d",
                           o_event_kind, o_slot_index, o_slot_value, o_frame_good);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
                        fail_count++;
                    end
                    if (o_slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, o_slot_index);
                        fail_count++;
                    end
                    if (o_slot_value !== want.slot_value) begin
                        $error("slot_value: expected %h, got %h",
                               want.slot_value, o_slot_value);
                        fail_count++;
                    end
                    if (o_frame_good !== want.frame_good) begin
                        $error("frame_good: expected %0d, got %0d",
                               want.frame_good, o_frame_good);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                got = deframe_byte(i_rx_byte, made);
                if (row_pinned) begin
                    if (row_has_res) begin
                        pending_results.push_back(row_res);
                    end
                end else if (got) begin
                    pending_results.push_back(made);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                trk_start_slot = i_cfg_start_slot;
            end
        end
    end

    // Hard stop on a hang
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result-side stalls: short runs, rare long runs, quiet stretches
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_out_stall = 1'b0;
            free_left--;
        end else begin
            i_out_stall = 1'b0;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 55) begin
                free_left = $urandom_range(0, 3);
            end else if (stall_roll < 85) begin
                stall_left = $urandom_range(1, 3);
            end else if (stall_roll < 95) begin
                free_left = $urandom_range(20, 60);
            end else begin
                stall_left = $urandom_range(10, 30);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Present one byte after a random gap and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] rx, input bit pinned,
                             input bit has_res, input t_result res);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_rx_byte   = rx;
        row_pinned  = pinned;
        row_has_res = has_res;
        row_res     = res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every result is out and the pipe is empty
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        row_pinned = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start_slot(input logic [IDX_W-1:0] slot);
        @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_start_slot = slot;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic void push_word(input logic [WORD_W-1:0] word);
        frame_bytes.push_back(word[7:0]);
        frame_bytes.push_back(word[15:8]);
    endfunction

    function automatic logic [WORD_W-1:0] plain_value();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return '0;
        end
        if (roll == 1) begin
            return TOP_VALUE;
        end
        return WORD_W'($urandom_range(0, 32'hff00));
    endfunction

    // Build one frame: mostly well formed, the rest damaged or noise
    function automatic void build_frame();
        int kind;
        int words;
        int bad_at;
        kind = $urandom_range(0, 99);
        frame_bytes.delete();
        if (kind >= 94) begin
            repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom()));
            return;
        end
        words  = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 6);
        bad_at = (kind >= 65 && kind < 75) ? $urandom_range(0, words) : -1;
        for (int k = 0; k < words; k++) begin
            if (k == bad_at) begin
                push_word(WORD_W'($urandom_range(32'hff01, 32'hfffe)));
            end
            push_word(plain_value());
        end
        push_word(END_MARK);
        if (kind >= 75 && kind < 82) begin
            push_word(END_MARK);
        end else if (kind >= 82 && kind < 88) begin
            frame_bytes.push_back(RESYNC_BYTE);
            return;
        end else if (kind >= 88) begin
            push_word(WORD_W'($urandom()));
        end
        push_word(CLOSE_WORD);
    endfunction

    t_row dir_rows[25];
    int   phase_sent;
    logic [IDX_W-1:0] phase_slots[5];

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_rx_byte        = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_start_slot = '0;

        dir_rows = '{
            // plain words at the reset start slot, lowest and highest value
            '{8'h00, 1'b1, 1'b0, NO_RESULT},
            '{8'h00, 1'b1, 1'b1, '{EV_WRITE, 11'd135, 16'h0000, 1'b0}},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b1, 1'b1, '{EV_WRITE, 11'd136, 16'hff00, 1'b0}},
            // word above the top value spoils, end mark restores, close is good
            '{8'h01, 1'b1, 1'b0, NO_RESULT},
            '{8'hff, 1'b1, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hf0, 1'b1, 1'b1, '{EV_END, 11'd0, 16'h0000, 1'b1}},
            // resync byte before any end mark is just a low byte
            '{8'hf0, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            // repeated end mark spoils the frame
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hf0, 1'b1, 1'b1, '{EV_END, 11'd0, 16'h0000, 1'b0}},
            // resync after the end mark closes the frame as bad
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hf0, 1'b1, 1'b1, '{EV_END, 11'd0, 16'h0000, 1'b0}},
            // ordinary word after the end mark spoils and is not written
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'hff, 1'b0, 1'b0, NO_RESULT},
            '{8'h12, 1'b0, 1'b0, NO_RESULT},
            '{8'h34, 1'b0, 1'b0, NO_RESULT}
        };
        phase_slots = '{11'd2047, 11'd0, 11'd2043, IDX_W'($urandom()), START_SLOT_RESET};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (dir_rows[n]) begin
            send_byte(dir_rows[n].rx, dir_rows[n].pinned, dir_rows[n].has_res,
                      dir_rows[n].res);
        end
        drain();

        // Random frames under each start slot
        foreach (phase_slots[p]) begin
            write_start_slot(phase_slots[p]);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                build_frame();
                burst = ($urandom_range(0, 7) == 0);
                foreach (frame_bytes[k]) begin
                    send_byte(frame_bytes[k], 1'b0, 1'b0, NO_RESULT);
                    phase_sent++;
                end
            end
            burst = 1'b0;
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
